/* design/wsm_pkg.sv */
package wsm_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 1024;
  localparam int unsigned DEF_CALL_DEPTH  = 256;
  localparam int unsigned DEF_HEAP_WORDS  = 4096;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IADDR_W = 16;

  typedef enum logic [4:0] {
    OP_PUSH   = 5'd0,
    OP_DUP    = 5'd1,
    OP_DROP   = 5'd2,
    OP_SWAP   = 5'd3,
    OP_GETC   = 5'd4,
    OP_PUTC   = 5'd5,
    OP_GETN   = 5'd6,
    OP_PUTN   = 5'd7,
    OP_ADD    = 5'd8,
    OP_SUB    = 5'd9,
    OP_MUL    = 5'd10,
    OP_DIV    = 5'd11,
    OP_MOD    = 5'd12,
    OP_STOP   = 5'd13,
    OP_STORE  = 5'd14,
    OP_RECALL = 5'd15,
    OP_JMP    = 5'd16,
    OP_BZ     = 5'd17,
    OP_BLTZ   = 5'd18,
    OP_CALL   = 5'd19,
    OP_RET    = 5'd20,
    OP_SLIDE  = 5'd21,
    OP_COPY   = 5'd22
  } opcode_t;

  typedef enum logic [1:0] {
    PC_NEXT = 2'd0,
    PC_JUMP = 2'd1,
    PC_RET  = 2'd2,
    PC_HALT = 2'd3
  } pc_action_t;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_CHAR = 2'd1,
    PK_NUM  = 2'd2
  } print_kind_t;

  typedef enum logic [2:0] {
    F_NONE      = 3'd0,
    F_STACK_UND = 3'd1,
    F_CALL_UND  = 3'd2,
    F_NEG_ADDR  = 3'd3,
    F_HEAP_RNG  = 3'd4,
    F_DIV_ZERO  = 3'd5,
    F_STACK_OVF = 3'd6,
    F_CALL_OVF  = 3'd7
  } fault_t;

endpackage

/* design/wsm_ram.sv */
module wsm_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/wsm_div.sv */
module wsm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  logic        want_mod,
  output logic        done,
  output logic [31:0] result
);

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] dvs_r;
  logic        na_r;
  logic        nq_r;
  logic        mod_r;
  logic        done_r;
  logic [31:0] shifted;
  logic        fits;

  assign shifted = {rem_r[30:0], quo_r[31]};
  assign fits    = (rem_r[31] == 1'b1) || (shifted >= dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
        rem_r  <= '0;
        quo_r  <= dividend[31] ? (32'd0 - dividend) : dividend;
        dvs_r  <= divisor[31] ? (32'd0 - divisor) : divisor;
        na_r   <= dividend[31];
        nq_r   <= dividend[31] ^ divisor[31];
        mod_r  <= want_mod;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= shifted - dvs_r;
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= shifted;
          quo_r <= {quo_r[30:0], 1'b0};
        end
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = mod_r ? (na_r ? (32'd0 - rem_r) : rem_r)
                        : (nq_r ? (32'd0 - quo_r) : quo_r);

endmodule

/* design/whitespace_stack_machine_execute_unit.sv */
// Sequence: an accepted input word passes through S_RDB, S_RDA, S_EXEC and S_DONE before
// out_tvalid rises; divide and modulo add S_DIV on the bit-serial divider, recall S_HEAP and swap S_WR2.
// Flow: one instruction at a time; the two data stack reads are taken one after
// another, and a new word is accepted only after the result register is loaded.
// Reset: synchronous active-low rst_n clears the depths and counter, then the
// heap is zeroed one word a cycle in S_CLEAR, before in_tready rises.
module whitespace_stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH = wsm_pkg::DEF_STACK_DEPTH,
  parameter int unsigned CALL_DEPTH  = wsm_pkg::DEF_CALL_DEPTH,
  parameter int unsigned HEAP_WORDS  = wsm_pkg::DEF_HEAP_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // immediate [31:0], instr_addr [47:32], host_value [79:48]
  input  logic [79:0] in_tdata,
  // func [4:0]
  input  logic [4:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pc_action [1:0], return_addr [17:2], print_value [49:18], fault [52:50],
  // executed_count [84:53]
  output logic [87:0] out_tdata,
  // print_kind [1:0]
  output logic [1:0]  out_tuser
);

  import wsm_pkg::*;

  localparam int unsigned DW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned RW  = $clog2(CALL_DEPTH + 1);
  localparam int unsigned RAW = $clog2(CALL_DEPTH);
  localparam int unsigned HAW = $clog2(HEAP_WORDS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDB, S_RDA, S_EXEC, S_DIV, S_HEAP, S_WR2, S_DONE
  } state_t;

  state_t      state_r;
  logic [HAW-1:0] clr_r;
  logic [DW-1:0]  d_r;
  logic [RW-1:0]  rd_r;
  logic [31:0]    cnt_r;
  logic [4:0]     op_r;
  logic [31:0]    imm_r;
  logic [15:0]    iaddr_r;
  logic [31:0]    host_r;
  logic [31:0]    b_r;
  logic [31:0]    a_r;
  logic           out_valid_r;
  logic [87:0]    out_data_r;
  logic [1:0]     out_user_r;
  logic [1:0]     res_act_r;
  logic [15:0]    res_raddr_r;
  logic [1:0]     res_pk_r;
  logic [31:0]    res_pv_r;
  logic [2:0]     res_f_r;
  logic           res_cnt_r;

  logic [DW-1:0]  dm1, dm2, dcopy, dslide;
  logic [31:0]    a_in;
  logic           under;
  logic [2:0]     f;
  logic [1:0]     act;
  logic [1:0]     pk;
  logic [31:0]    pv;
  logic [15:0]    raddr;
  logic [32:0]    need_n;

  logic           ds_we, ds_re, rs_we, rs_re, hp_we, hp_re;
  logic [AW-1:0]  ds_waddr, ds_raddr;
  logic [31:0]    ds_wdata, ds_rdata;
  logic [RAW-1:0] rs_waddr, rs_raddr;
  logic [15:0]    rs_rdata;
  logic [HAW-1:0] hp_waddr, hp_raddr;
  logic [31:0]    hp_wdata, hp_rdata;
  logic           div_start, div_done;
  logic [31:0]    div_result;

  assign dm1    = d_r - DW'(1);
  assign dm2    = d_r - DW'(2);
  assign dcopy  = d_r - DW'(1) - imm_r[DW-1:0];
  assign dslide = d_r - imm_r[DW-1:0];
  assign a_in   = ds_rdata;
  assign need_n = {1'b0, imm_r} + 33'd1;

  function automatic logic [2:0] addr_check(input logic [31:0] v);
    logic [2:0] r;
    r = F_NONE;
    if (v[31]) begin
      r = F_NEG_ADDR;
    end else if (v >= 32'(HEAP_WORDS)) begin
      r = F_HEAP_RNG;
    end
    return r;
  endfunction

  always_comb begin
    unique case (op_r)
      OP_DUP, OP_DROP, OP_GETC, OP_PUTC, OP_GETN, OP_PUTN, OP_RECALL, OP_BZ,
      OP_BLTZ: under = (d_r == '0);
      OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_STORE:
        under = (d_r < DW'(2));
      OP_SLIDE, OP_COPY: under = imm_r[31] || (need_n > 33'(d_r));
      default: under = 1'b0;
    endcase
  end

  // Per-state decode: memory read and write controls, divider start, and in S_EXEC the fault and result fields.
  always_comb begin
    f = F_NONE; act = PC_NEXT; pk = PK_NONE; pv = '0; raddr = '0;
    ds_we = 1'b0; ds_waddr = dm1[AW-1:0]; ds_wdata = b_r;
    ds_re = 1'b0; ds_raddr = dm1[AW-1:0];
    rs_we = 1'b0; rs_waddr = rd_r[RAW-1:0]; rs_re = 1'b0; rs_raddr = rd_r[RAW-1:0] - RAW'(1);
    hp_we = 1'b0; hp_waddr = clr_r; hp_wdata = '0; hp_re = 1'b0; hp_raddr = b_r[HAW-1:0];
    div_start = 1'b0;
    unique case (state_r)
      S_CLEAR: hp_we = 1'b1;
      S_RDB: begin
        ds_re = 1'b1;
        rs_re = 1'b1;
      end
      S_RDA: begin
        ds_re = 1'b1;
        ds_raddr = (op_r == OP_COPY) ? dcopy[AW-1:0] : dm2[AW-1:0];
      end
      S_EXEC: begin
        if (under) begin
          f = F_STACK_UND;
        end else begin
          unique case (op_r)
            OP_PUSH, OP_DUP, OP_COPY: begin
              if (d_r >= DW'(STACK_DEPTH)) begin
                f = F_STACK_OVF;
              end else begin
                ds_we = 1'b1;
                ds_waddr = d_r[AW-1:0];
                ds_wdata = (op_r == OP_PUSH) ? imm_r : (op_r == OP_DUP) ? b_r : a_in;
              end
            end
            OP_SWAP: begin
              ds_we = 1'b1;
              ds_waddr = dm2[AW-1:0];
            end
            OP_GETC, OP_GETN: begin
              f = addr_check(b_r);
              hp_we = (f == F_NONE);
              hp_waddr = b_r[HAW-1:0];
              hp_wdata = host_r;
            end
            OP_PUTC, OP_PUTN: begin
              pk = (op_r == OP_PUTC) ? PK_CHAR : PK_NUM;
              pv = b_r;
            end
            OP_ADD, OP_SUB, OP_MUL: begin
              ds_we = 1'b1;
              ds_waddr = dm2[AW-1:0];
              ds_wdata = (op_r == OP_ADD) ? a_in + b_r :
                         (op_r == OP_SUB) ? a_in - b_r : a_in * b_r;
            end
            OP_DIV, OP_MOD: begin
              if (b_r == '0) begin
                f = F_DIV_ZERO;
              end else begin
                div_start = 1'b1;
              end
            end
            OP_STOP: act = PC_HALT;
            OP_STORE: begin
              f = addr_check(a_in);
              hp_we = (f == F_NONE);
              hp_waddr = a_in[HAW-1:0];
              hp_wdata = b_r;
            end
            OP_RECALL: begin
              f = addr_check(b_r);
              hp_re = (f == F_NONE);
            end
            OP_JMP: act = PC_JUMP;
            OP_BZ: act = (b_r == '0) ? PC_JUMP : PC_NEXT;
            OP_BLTZ: act = b_r[31] ? PC_JUMP : PC_NEXT;
            OP_CALL: begin
              if (rd_r >= RW'(CALL_DEPTH)) begin
                f = F_CALL_OVF;
              end else begin
                rs_we = 1'b1;
                act = PC_JUMP;
              end
            end
            OP_RET: begin
              if (rd_r == '0) begin
                f = F_CALL_UND;
              end else begin
                act = PC_RET;
                raddr = rs_rdata;
              end
            end
            OP_SLIDE: begin
              ds_we = 1'b1;
              ds_waddr = dcopy[AW-1:0];
            end
            default: ;
          endcase
        end
        if (f != F_NONE) begin
          act = PC_HALT; pk = PK_NONE; pv = '0; raddr = '0;
          ds_we = 1'b0; hp_we = 1'b0; rs_we = 1'b0; hp_re = 1'b0; div_start = 1'b0;
        end
      end
      S_DIV: begin
        ds_we = div_done;
        ds_waddr = dm2[AW-1:0];
        ds_wdata = div_result;
      end
      S_HEAP: begin
        ds_we = 1'b1;
        ds_wdata = hp_rdata;
      end
      S_WR2: begin
        ds_we = 1'b1;
        ds_wdata = a_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      d_r         <= '0;
      rd_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + HAW'(1);
          if (clr_r == HAW'(HEAP_WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tuser;
            imm_r   <= in_tdata[31:0];
            iaddr_r <= in_tdata[47:32];
            host_r  <= in_tdata[79:48];
            state_r <= S_RDB;
          end
        end
        S_RDB: state_r <= S_RDA;
        S_RDA: begin
          b_r     <= ds_rdata;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          a_r         <= a_in;
          res_act_r   <= act;
          res_raddr_r <= raddr;
          res_pk_r    <= pk;
          res_pv_r    <= pv;
          res_f_r     <= f;
          res_cnt_r   <= (f == F_NONE) && (op_r != OP_STOP);
          state_r     <= S_DONE;
          if (f == F_NONE) begin
            unique case (op_r)
              OP_PUSH, OP_DUP, OP_COPY: d_r <= d_r + DW'(1);
              OP_DROP, OP_PUTC, OP_PUTN, OP_ADD, OP_SUB, OP_MUL, OP_BZ, OP_BLTZ,
              OP_GETC, OP_GETN:
                d_r <= dm1;
              OP_STORE: d_r <= dm2;
              OP_SLIDE: d_r <= dslide;
              OP_CALL: rd_r <= rd_r + RW'(1);
              OP_RET: rd_r <= rd_r - RW'(1);
              default: ;
            endcase
            unique case (op_r)
              OP_DIV, OP_MOD: state_r <= S_DIV;
              OP_RECALL: state_r <= S_HEAP;
              OP_SWAP: state_r <= S_WR2;
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            d_r     <= dm1;
            state_r <= S_DONE;
          end
        end
        S_HEAP: state_r <= S_DONE;
        S_WR2: state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= res_pk_r;
            out_data_r  <= {3'b000, cnt_r + 32'(res_cnt_r), res_f_r, res_pv_r,
                            res_raddr_r, res_act_r};
            cnt_r       <= cnt_r + 32'(res_cnt_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  wsm_ram #(.DEPTH(STACK_DEPTH), .WIDTH(32)) u_data_stack (
    .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
    .re(ds_re), .raddr(ds_raddr), .rdata(ds_rdata)
  );

  wsm_ram #(.DEPTH(CALL_DEPTH), .WIDTH(16)) u_call_stack (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(iaddr_r),
    .re(rs_re), .raddr(rs_raddr), .rdata(rs_rdata)
  );

  wsm_ram #(.DEPTH(HEAP_WORDS), .WIDTH(32)) u_heap (
    .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
    .re(hp_re), .raddr(hp_raddr), .rdata(hp_rdata)
  );

  wsm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(a_in), .divisor(b_r),
    .want_mod(op_r == OP_MOD), .done(div_done), .result(div_result)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* tb/whitespace_stack_machine_execute_unit_checker.sv */
module whitespace_stack_machine_execute_unit_checker
  import wsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic [4:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          pending,
  output int          mismatches,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pc_action_t  action;
    logic [15:0] ret_addr;
    print_kind_t pkind;
    logic [31:0] pvalue;
    fault_t      fault;
    logic [31:0] count;
  } exec_result_t;

  logic [31:0] data_mem [DEF_STACK_DEPTH];
  int unsigned data_top;
  logic [15:0] call_mem [DEF_CALL_DEPTH];
  int unsigned call_top;
  logic [31:0] heap_mem [DEF_HEAP_WORDS];
  logic [31:0] exec_count;
  exec_result_t expected_results [$];

  function automatic fault_t heap_addr_fault(logic [31:0] addr);
    if (addr[31]) return F_NEG_ADDR;
    if (addr >= DEF_HEAP_WORDS) return F_HEAP_RNG;
    return F_NONE;
  endfunction

  task automatic execute_word(logic [4:0] op, logic [31:0] imm, logic [15:0] iaddr,
                              logic [31:0] host, output exec_result_t r);
    longint need;
    logic [31:0] a, b, ma, mb, q, rm;
    fault_t f;
    int unsigned d;
    d = data_top;
    r = '0;
    f = F_NONE;
    a = '0;
    b = '0;
    case (op)
      OP_DUP, OP_DROP, OP_GETC, OP_PUTC, OP_GETN, OP_PUTN, OP_RECALL, OP_BZ, OP_BLTZ:
        need = 1;
      OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_STORE: need = 2;
      OP_SLIDE, OP_COPY: need = imm[31] ? 64'h7fff_ffff_ffff : longint'(imm) + 1;
      default: need = 0;
    endcase
    if (longint'(d) < need) f = F_STACK_UND;
    if (f == F_NONE && need >= 1) b = data_mem[d-1];
    if (f == F_NONE && need == 2) a = data_mem[d-2];
    if (f == F_NONE) begin
      case (op)
        OP_PUSH, OP_DUP: begin
          if (d >= DEF_STACK_DEPTH) f = F_STACK_OVF;
          else begin
            data_mem[d] = (op == OP_PUSH) ? imm : b;
            data_top = d + 1;
          end
        end
        OP_DROP: data_top = d - 1;
        OP_SWAP: begin
          data_mem[d-2] = b;
          data_mem[d-1] = a;
        end
        OP_GETC, OP_GETN: begin
          f = heap_addr_fault(b);
          if (f == F_NONE) begin
            heap_mem[b] = host;
            data_top = d - 1;
          end
        end
        OP_PUTC, OP_PUTN: begin
          r.pkind = (op == OP_PUTC) ? PK_CHAR : PK_NUM;
          r.pvalue = b;
          data_top = d - 1;
        end
        OP_ADD, OP_SUB, OP_MUL: begin
          data_mem[d-2] = (op == OP_ADD) ? a + b : (op == OP_SUB) ? a - b : a * b;
          data_top = d - 1;
        end
        OP_DIV, OP_MOD: begin
          if (b == 0) f = F_DIV_ZERO;
          else begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            rm = ma % mb;
            if (op == OP_MOD) data_mem[d-2] = a[31] ? -rm : rm;
            else data_mem[d-2] = (a[31] ^ b[31]) ? -q : q;
            data_top = d - 1;
          end
        end
        OP_STOP: r.action = PC_HALT;
        OP_STORE: begin
          f = heap_addr_fault(a);
          if (f == F_NONE) begin
            heap_mem[a] = b;
            data_top = d - 2;
          end
        end
        OP_RECALL: begin
          f = heap_addr_fault(b);
          if (f == F_NONE) data_mem[d-1] = heap_mem[b];
        end
        OP_JMP: r.action = PC_JUMP;
        OP_BZ, OP_BLTZ: begin
          if (op == OP_BZ ? (b == 0) : b[31]) r.action = PC_JUMP;
          data_top = d - 1;
        end
        OP_CALL: begin
          if (call_top >= DEF_CALL_DEPTH) f = F_CALL_OVF;
          else begin
            call_mem[call_top] = iaddr;
            call_top++;
            r.action = PC_JUMP;
          end
        end
        OP_RET: begin
          if (call_top == 0) f = F_CALL_UND;
          else begin
            call_top--;
            r.ret_addr = call_mem[call_top];
            r.action = PC_RET;
          end
        end
        OP_SLIDE: begin
          data_mem[d-1-imm] = data_mem[d-1];
          data_top = d - imm;
        end
        OP_COPY: begin
          if (d >= DEF_STACK_DEPTH) f = F_STACK_OVF;
          else begin
            data_mem[d] = data_mem[d-1-imm];
            data_top = d + 1;
          end
        end
        default: ;
      endcase
    end
    if (f != F_NONE) begin
      r.action = PC_HALT;
      r.ret_addr = '0;
      r.pkind = PK_NONE;
      r.pvalue = '0;
    end else if (op != OP_STOP) begin
      exec_count++;
    end
    r.fault = f;
    r.count = exec_count;
  endtask

  assign pending = expected_results.size();

  always @(posedge clk) begin
    exec_result_t want, got;
    if (!rst_n) begin
      data_top <= 0;
      call_top <= 0;
      exec_count <= '0;
      mismatches <= 0;
      checked <= 0;
      expected_results.delete();
      for (int i = 0; i < DEF_HEAP_WORDS; i++) heap_mem[i] = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        execute_word(in_tuser, in_tdata[31:0], in_tdata[47:32], in_tdata[79:48], want);
        expected_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.action = pc_action_t'(out_tdata[1:0]);
        got.ret_addr = out_tdata[17:2];
        got.pvalue = out_tdata[49:18];
        got.fault = fault_t'(out_tdata[52:50]);
        got.count = out_tdata[84:53];
        got.pkind = print_kind_t'(out_tuser);
        checked <= checked + 1;
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("Unexpected result word: %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.action !== want.action || got.ret_addr !== want.ret_addr ||
              got.pkind !== want.pkind || got.pvalue !== want.pvalue ||
              got.fault !== want.fault || got.count !== want.count) begin
            if (mismatches < 10)
              $display("Result mismatch: expected %p, actual %p", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/whitespace_stack_machine_execute_unit_test.sv */
module whitespace_stack_machine_execute_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wsm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [4:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  int          pending;
  int          mismatches;
  int          checked;
  bit          sender_idles;
  bit          receiver_stalls;
  int          idle_pct;
  int          words_sent;

  whitespace_stack_machine_execute_unit dut (.*);

  whitespace_stack_machine_execute_unit_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk)
    out_tready <= receiver_stalls ? ($urandom_range(99) >= idle_pct) : 1'b1;

  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send(logic [4:0] op, logic [31:0] imm, logic [31:0] host = $urandom);
    if (sender_idles) begin
      while ($urandom_range(99) < idle_pct) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {host, 16'($urandom), imm};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_heap_addr();
    case ($urandom_range(9))
      0: return 32'h8000_0000 | $urandom;
      1: return $urandom_range(32'hffff_ffff, DEF_HEAP_WORDS);
      2: return DEF_HEAP_WORDS - 1;
      default: return $urandom_range(15);
    endcase
  endfunction

  task automatic random_sequence();
    logic [31:0] addr;
    addr = pick_heap_addr();
    case ($urandom_range(7))
      0: begin
        if ($urandom_range(3) == 0) begin
          send(OP_PUSH, 32'h8000_0000);
          send(OP_PUSH, 32'hffff_ffff);
        end else begin
          send(OP_PUSH, pick_value());
          send(OP_PUSH, ($urandom_range(4) == 0) ? 32'd0 : pick_value());
        end
        send(5'($urandom_range(OP_MOD, OP_ADD)), 0);
        send(OP_PUTN, 0);
      end
      1: begin
        send(OP_PUSH, addr);
        send(OP_PUSH, pick_value());
        send(OP_STORE, 0);
        send(OP_PUSH, ($urandom_range(1) == 0) ? addr : pick_heap_addr());
        send(OP_RECALL, 0);
        send(OP_PUTC, 0);
      end
      2: begin
        send(OP_PUSH, addr);
        send($urandom_range(1) ? OP_GETC : OP_GETN, 0,
             ($urandom_range(3) == 0) ? 32'hffff_ffff : $urandom);
      end
      3: begin
        send(OP_PUSH, pick_value());
        send($urandom_range(1) ? OP_BZ : OP_BLTZ, $urandom);
        send(OP_JMP, $urandom);
      end
      4: begin
        send(OP_CALL, $urandom);
        if ($urandom_range(2) != 0) send(OP_RET, 0);
      end
      5: begin
        send(OP_PUSH, pick_value());
        send(OP_PUSH, pick_value());
        send(OP_PUSH, pick_value());
        send(5'($urandom_range(OP_SWAP, OP_DUP)), 0);
        send(OP_COPY, $urandom_range(4));
        send(OP_SLIDE, $urandom_range(5));
        send(OP_DROP, 0);
      end
      6: send(OP_STOP, $urandom);
      default: send(5'($urandom), ($urandom_range(1) == 0) ? $urandom : $urandom_range(3));
    endcase
  endtask

  task automatic deep_stacks();
    send(OP_COPY, DEF_STACK_DEPTH - 1);
    send(OP_SLIDE, DEF_STACK_DEPTH + 10);
    repeat (DEF_CALL_DEPTH + 3) send(OP_CALL, $urandom);
    repeat (DEF_CALL_DEPTH + 3) send(OP_RET, 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    sender_idles = 1'b0;
    receiver_stalls = 1'b0;
    idle_pct = 83;
    words_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(OP_DROP, 0);
    send(OP_RET, 0);
    send(OP_PUSH, 32'h7fff_ffff);
    send(OP_PUSH, 32'h8000_0000);
    send(OP_SWAP, 0);
    send(OP_DUP, 0);
    send(OP_ADD, 0);
    send(OP_PUSH, 32'h8000_0000);
    send(OP_PUSH, 32'hffff_ffff);
    send(OP_DIV, 0);
    send(OP_PUSH, 32'd0);
    send(OP_MOD, 0);
    send(OP_PUSH, DEF_HEAP_WORDS - 1);
    send(OP_GETC, 0, 32'hffff_ffff);
    send(OP_PUSH, DEF_HEAP_WORDS - 1);
    send(OP_RECALL, 0);
    send(OP_PUTN, 0);
    send(OP_COPY, 32'hffff_ffff);
    send(OP_COPY, 0);
    send(OP_SLIDE, 1);
    send(OP_CALL, 0);
    send(OP_RET, 0);
    send(OP_STOP, 0);
    send(5'd31, 0);
    send(OP_BLTZ, 0);

    for (int phase = 0; phase < 4; phase++) begin
      sender_idles = (phase == 1 || phase == 3);
      receiver_stalls = (phase == 2 || phase == 3);
      idle_pct = (phase == 3) ? 37 : 83;
      repeat (24) random_sequence();
      if (phase == 2) deep_stacks();
      in_tvalid <= 1'b0;
      while (pending != 0) @(negedge clk);
    end

    repeat (60) @(posedge clk);
    $display("Executed %0d instruction words and checked %0d results in four handshake modes,",
             words_sent, checked);
    $display("including a full call stack, heap limits and divide corner cases.");
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
design/wsm_pkg.sv
design/wsm_ram.sv
design/wsm_div.sv
design/whitespace_stack_machine_execute_unit.sv
tb/whitespace_stack_machine_execute_unit_checker.sv
tb/whitespace_stack_machine_execute_unit_test.sv
